@@ hdl/mmc_pkg.sv @@
// Package for the MMC command line transceiver: constants, item types and phase codes.
package mmc_pkg;

  localparam int COMMAND_BYTES   = 6;
  localparam int PREAMBLE_CLOCKS = 2;

  localparam int FRAME_BITS = COMMAND_BYTES * 8;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'hFFFF;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_SEND = 3'd2,
    PH_WAIT = 3'd3,
    PH_RECV = 3'd4
  } phase_t;

  typedef struct packed {
    logic        start_req;
    logic [7:0]  command_byte;
    logic [31:0] argument;
    logic [7:0]  crc_byte;
    logic [7:0]  response_bits;
    logic        line_in;
  } in_item_t;

  typedef struct packed {
    logic       line_out;
    logic       line_drive;
    logic [7:0] response_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
  } out_item_t;

endpackage

@@ hdl/mmc_cmd_line_transceiver_unit.sv @@
// Top level of the MMC command line transceiver.
// Results are registered: input register, controller logic, result register.
// Throughput: one item per cycle while res_ready allows; the input register and the result register
// decouple the two sides, and the phase state advances once per item.
// Reset (rst, synchronous, active high): phase idle, counters and shifter cleared,
// both item registers empty, response timeout set to 65535.
module mmc_cmd_line_transceiver_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  mmc_pkg::in_item_t  cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output mmc_pkg::out_item_t res,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic               held_valid;
  mmc_pkg::in_item_t  held;
  logic               load_ready;
  logic               step;
  mmc_pkg::out_item_t result;

  assign step = held_valid && load_ready;

  mmc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .take       (step),
    .held_valid (held_valid),
    .held       (held)
  );

  mmc_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (held),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (result)
  );

  mmc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .load_ready (load_ready),
    .load       (result),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

@@ hdl/mmc_in_reg.sv @@
// Input register slice: holds one accepted item until the controller takes it.
module mmc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mmc_pkg::in_item_t cmd,
  input  logic              take,
  output logic              held_valid,
  output mmc_pkg::in_item_t held
);

  assign cmd_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd_ready) begin
      held_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      held <= cmd;
    end
  end

endmodule

@@ hdl/mmc_ctl.sv @@
// Transaction controller: phase machine, frame shifter, response assembly and timeout.
module mmc_ctl (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mmc_pkg::in_item_t  item,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  output mmc_pkg::out_item_t result
);

  mmc_pkg::phase_t                  phase, phase_next;
  logic [mmc_pkg::FRAME_BITS-1:0]   command_shift, command_shift_next;
  logic [mmc_pkg::CNT_W-1:0]        bit_count, bit_count_next;
  logic [15:0]                      wait_count, wait_count_next;
  logic [7:0]                       byte_accum, byte_accum_next;
  logic [7:0]                       bits_left, bits_left_next;
  logic [15:0]                      response_timeout;

  logic [mmc_pkg::CNT_W:0]          cnt_inc;
  logic                             pre_done, send_done;
  logic [63:0]                      frame_full;
  logic [15:0]                      wait_inc, limit;
  logic                             timed_out;
  logic                             tb_bit;
  logic [7:0]                       tb_acc_base, tb_acc, tb_byte;
  logic [mmc_pkg::CNT_W:0]          tb_cnt;
  logic [7:0]                       tb_left;
  logic                             tb_full, tb_emit, tb_end;

  assign cnt_inc   = {1'b0, bit_count} + 1'b1;
  assign pre_done  = cnt_inc >= (mmc_pkg::CNT_W + 1)'(mmc_pkg::PREAMBLE_CLOCKS);
  assign send_done = cnt_inc >= (mmc_pkg::CNT_W + 1)'(mmc_pkg::FRAME_BITS);

  // Filler bytes beyond the six frame bytes are all ones.
  assign frame_full = {item.command_byte, item.argument, item.crc_byte, 16'hFFFF};

  assign wait_inc  = wait_count + 16'd1;
  assign limit     = (response_timeout == 16'd0) ? 16'd1 : response_timeout;
  assign timed_out = wait_inc >= limit;

  // In the wait phase the low start bit is the first bit of a fresh byte.
  always_comb begin
    tb_bit      = (phase == mmc_pkg::PH_WAIT) ? 1'b0 : item.line_in;
    tb_acc_base = (phase == mmc_pkg::PH_WAIT) ? 8'd0 : byte_accum;
    tb_cnt      = (phase == mmc_pkg::PH_WAIT) ? (mmc_pkg::CNT_W + 1)'(1)
                                              : cnt_inc;
    tb_left     = bits_left - 8'd1;
    tb_acc      = {tb_acc_base[6:0], tb_bit};
    tb_full     = tb_cnt >= (mmc_pkg::CNT_W + 1)'(8);
    tb_end      = tb_left == 8'd0;
    tb_emit     = tb_full || tb_end;
    tb_byte     = tb_full ? tb_acc : (tb_acc << (4'd8 - tb_cnt[3:0]));
  end

  always_comb begin
    phase_next = phase;
    if (item.start_req) begin
      phase_next = (mmc_pkg::PREAMBLE_CLOCKS > 0) ? mmc_pkg::PH_PRE : mmc_pkg::PH_SEND;
    end else begin
      unique case (phase)
        mmc_pkg::PH_IDLE: phase_next = mmc_pkg::PH_IDLE;
        mmc_pkg::PH_PRE: begin
          if (pre_done) phase_next = mmc_pkg::PH_SEND;
        end
        mmc_pkg::PH_SEND: begin
          if (send_done) begin
            phase_next = (bits_left == 8'd0) ? mmc_pkg::PH_IDLE : mmc_pkg::PH_WAIT;
          end
        end
        mmc_pkg::PH_WAIT: begin
          if (!item.line_in) begin
            phase_next = tb_end ? mmc_pkg::PH_IDLE : mmc_pkg::PH_RECV;
          end else if (timed_out) begin
            phase_next = mmc_pkg::PH_IDLE;
          end
        end
        mmc_pkg::PH_RECV: begin
          if (tb_end) phase_next = mmc_pkg::PH_IDLE;
        end
        default: phase_next = mmc_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    command_shift_next = command_shift;
    bit_count_next     = bit_count;
    wait_count_next    = wait_count;
    byte_accum_next    = byte_accum;
    bits_left_next     = bits_left;
    result             = '{line_out: 1'b1, line_drive: 1'b1, response_byte: 8'd0,
                           byte_valid: 1'b0, last: 1'b0, status: mmc_pkg::ST_BUSY};
    if (item.start_req) begin
      command_shift_next = frame_full[63 -: mmc_pkg::FRAME_BITS];
      bits_left_next     = item.response_bits;
      bit_count_next     = '0;
      wait_count_next    = 16'd0;
      byte_accum_next    = 8'd0;
    end else begin
      unique case (phase) inside
        mmc_pkg::PH_IDLE: begin
        end
        mmc_pkg::PH_PRE: begin
          bit_count_next = pre_done ? '0 : cnt_inc[mmc_pkg::CNT_W-1:0];
        end
        mmc_pkg::PH_SEND: begin
          result.line_out    = command_shift[mmc_pkg::FRAME_BITS-1];
          command_shift_next = {command_shift[mmc_pkg::FRAME_BITS-2:0], 1'b0};
          bit_count_next     = send_done ? '0 : cnt_inc[mmc_pkg::CNT_W-1:0];
          if (send_done) begin
            if (bits_left == 8'd0) begin
              result.last   = 1'b1;
              result.status = mmc_pkg::ST_OK;
            end else begin
              wait_count_next = 16'd0;
            end
          end
        end
        mmc_pkg::PH_WAIT, mmc_pkg::PH_RECV: begin
          result.line_drive = 1'b0;
          if (phase == mmc_pkg::PH_WAIT && item.line_in) begin
            wait_count_next = wait_inc;
            if (timed_out) begin
              result.last   = 1'b1;
              result.status = mmc_pkg::ST_TIMEOUT;
            end
          end else begin
            bits_left_next  = tb_left;
            bit_count_next  = tb_emit ? '0 : tb_cnt[mmc_pkg::CNT_W-1:0];
            byte_accum_next = tb_emit ? 8'd0 : tb_acc;
            if (tb_emit) begin
              result.response_byte = tb_byte;
              result.byte_valid    = 1'b1;
            end
            if (tb_end) begin
              result.last   = 1'b1;
              result.status = mmc_pkg::ST_OK;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mmc_pkg::PH_IDLE;
      command_shift <= '0;
      bit_count     <= '0;
      wait_count    <= 16'd0;
      byte_accum    <= 8'd0;
      bits_left     <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      command_shift <= command_shift_next;
      bit_count     <= bit_count_next;
      wait_count    <= wait_count_next;
      byte_accum    <= byte_accum_next;
      bits_left     <= bits_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_timeout <= mmc_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      response_timeout <= cfg_wr_data;
    end
  end

endmodule

@@ hdl/mmc_out_reg.sv @@
// Result register: holds one result item until the consumer takes it.
module mmc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  output logic               load_ready,
  input  mmc_pkg::out_item_t load,
  output logic               res_valid,
  input  logic               res_ready,
  output mmc_pkg::out_item_t res
);

  assign load_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_ready) begin
      res_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res <= load;
    end
  end

endmodule

@@ hdl/mmc_checker.sv @@
// Port-level checker for the MMC command line transceiver, bound to the top level.
module mmc_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input mmc_pkg::out_item_t res
);

  // A stalled result item holds its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  // A final status only comes with the end of a transaction.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != mmc_pkg::ST_BUSY) |-> res.last)
    else $error("status set without last");

  // The response byte is zero unless it carries a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.byte_valid |-> res.response_byte == 8'd0)
    else $error("response byte nonzero without byte valid");

  // A released line always reads as high, and bytes arrive only while released.
  a_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && (!res.line_drive || res.byte_valid) |-> res.line_out && !res.line_drive)
    else $error("line level or drive wrong while receiving");

endmodule

bind mmc_cmd_line_transceiver_unit mmc_checker u_mmc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
